/* design/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and helpers for the seven-segment hh:mm:ss clock
// Transaction structs, counter widths and the digit/segment decode functions.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int TICK_COUNT_BITS = 10;
  localparam int TPS_BITS        = 10;
  // common width for comparing the tick counter against the configured count
  localparam int CMP_BITS        = (TICK_COUNT_BITS > TPS_BITS) ?
                                   TICK_COUNT_BITS + 1 : TPS_BITS + 1;

  localparam logic [TPS_BITS-1:0] TPS_RESET  = TPS_BITS'(100);
  localparam logic [5:0]          SEC_MAX    = 6'd59;
  localparam logic [5:0]          MIN_MAX    = 6'd59;
  localparam logic [4:0]          HOUR_MAX   = 5'd23;
  localparam logic [7:0]          SEG_DOT    = 8'h80;
  localparam logic [1:0]          SCAN_LAST  = 2'd3;

  typedef logic [TICK_COUNT_BITS-1:0] cnt_t;
  typedef logic [TPS_BITS-1:0]        tps_t;
  typedef logic [CMP_BITS-1:0]        cmp_t;

  typedef struct packed {
    logic tick;
    logic switch_pressed;
    logic advance_digit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] segments_n;
    logic [3:0] digit_select_n;
    logic [4:0] hours_now;
    logic [5:0] minutes_now;
    logic [5:0] seconds_now;
    logic       half_second_dot;
    logic       showing_min_sec;
  } out_item_t;

  // tens digit of a value up to 59
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd50)      t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else                 t = 4'd0;
    return t;
  endfunction

  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [5:0] tens10;
    tens10 = 6'(tens_of(v)) * 6'd10;
    return 4'(v - tens10);
  endfunction

  // active-high segments a..g, bit 0 = a
  function automatic logic [7:0] seg_font(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] digit_sel_n(input logic [1:0] pos);
    logic [3:0] s;
    case (pos)
      2'd0:    s = 4'hE;
      2'd1:    s = 4'hD;
      2'd2:    s = 4'hB;
      default: s = 4'h7;
    endcase
    return s;
  endfunction

endpackage

/* design/seven_segment_clock_hh_mm_ss_unit.sv */
// ----------------------------------------------------------------------------
// seven_segment_clock_hh_mm_ss_unit: multiplexed hh:mm:ss seven-segment clock
// Counts ticks, keeps the time, handles the mode switch and drives one digit.
// ----------------------------------------------------------------------------
// The result of an accepted input is captured in the output register in the cycle after acceptance.
// Throughput: one transaction per cycle; set by the single output register,
// which takes a new result whenever it is empty or being drained.
// Reset (rst, synchronous): time, tick counter, dot, switch and scan state
// clear to zero, ticks_per_second returns to 100, output register empties.
module seven_segment_clock_hh_mm_ss_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  ssc_pkg::tps_t              cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ssc_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ssc_pkg::out_item_t         out_data
);

  ssc_pkg::tps_t      tps;
  ssc_pkg::cnt_t      tick_counter, tick_counter_next;
  logic [5:0]         seconds, seconds_next;
  logic [5:0]         minutes, minutes_next;
  logic [4:0]         hours, hours_next;
  logic               dot, dot_next;
  logic               switch_held, switch_held_next;
  logic               min_sec, min_sec_next;
  logic [1:0]         scan, scan_next;
  ssc_pkg::out_item_t result;
  logic               in_accept;
  ssc_pkg::cnt_t      cnt_inc;
  logic [2:0]         digit_idx;
  logic [5:0]         shown_val;
  logic [3:0]         digit;
  logic [7:0]         seg;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    tick_counter_next = tick_counter;
    seconds_next      = seconds;
    minutes_next      = minutes;
    hours_next        = hours;
    dot_next          = dot;
    cnt_inc           = tick_counter + ssc_pkg::cnt_t'(1);

    if (in_data.tick) begin
      if (ssc_pkg::cmp_t'(tick_counter) == ssc_pkg::cmp_t'(tps >> 1)) begin
        dot_next = ~dot_next;
      end
      tick_counter_next = cnt_inc;
      if (ssc_pkg::cmp_t'(cnt_inc) >= ssc_pkg::cmp_t'(tps)) begin
        dot_next          = ~dot_next;
        tick_counter_next = '0;
        // seconds, then minutes, then hours carry
        if (seconds == ssc_pkg::SEC_MAX) begin
          seconds_next = '0;
          if (minutes == ssc_pkg::MIN_MAX) begin
            minutes_next = '0;
            if (hours == ssc_pkg::HOUR_MAX) begin
              hours_next = '0;
            end else begin
              hours_next = hours + 5'd1;
            end
          end else begin
            minutes_next = minutes + 6'd1;
          end
        end else begin
          seconds_next = seconds + 6'd1;
        end
      end
    end

    // rising level on the switch flips the display mode
    switch_held_next = in_data.switch_pressed;
    min_sec_next     = min_sec ^ (in_data.switch_pressed & ~switch_held);

    scan_next = in_data.advance_digit ? scan + 2'd1 : scan;

    digit_idx = {1'b0, scan_next} + (min_sec_next ? 3'd2 : 3'd0);
    case (digit_idx[2:1])
      2'd0:    shown_val = {1'b0, hours_next};
      2'd1:    shown_val = minutes_next;
      default: shown_val = seconds_next;
    endcase
    digit = digit_idx[0] ? ssc_pkg::units_of(shown_val) : ssc_pkg::tens_of(shown_val);
    seg   = ssc_pkg::seg_font(digit);
    if (scan_next == ssc_pkg::SCAN_LAST && dot_next) begin
      seg = seg | ssc_pkg::SEG_DOT;
    end

    result.segments_n      = ~seg;
    result.digit_select_n  = ssc_pkg::digit_sel_n(scan_next);
    result.hours_now       = hours_next;
    result.minutes_now     = minutes_next;
    result.seconds_now     = seconds_next;
    result.half_second_dot = dot_next;
    result.showing_min_sec = min_sec_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tps          <= ssc_pkg::TPS_RESET;
      tick_counter <= '0;
      seconds      <= '0;
      minutes      <= '0;
      hours        <= '0;
      dot          <= 1'b0;
      switch_held  <= 1'b0;
      min_sec      <= 1'b0;
      scan         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tps <= cfg_wr_data;
      end
      if (in_accept) begin
        tick_counter <= tick_counter_next;
        seconds      <= seconds_next;
        minutes      <= minutes_next;
        hours        <= hours_next;
        dot          <= dot_next;
        switch_held  <= switch_held_next;
        min_sec      <= min_sec_next;
        scan         <= scan_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

  // time registers never leave their wrap ranges
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    seconds <= ssc_pkg::SEC_MAX && minutes <= ssc_pkg::MIN_MAX &&
    hours <= ssc_pkg::HOUR_MAX)
    else $error("time count out of range");

  // an accepted transaction always lands in the output register
  a_accept_to_out: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted transaction produced no result");

  // exactly one digit enabled, matching the scan position
  a_digit_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(~out_data.digit_select_n) &&
                  out_data.digit_select_n == ssc_pkg::digit_sel_n(scan))
    else $error("digit select not one-hot or out of step with scan");

endmodule
